// ===== hw/rtl/stwt_pkg.sv =====
// ----------------------------------------------------------------------------
// stwt_pkg
// Types and constants shared by the stopwatch / countdown timer.
// ----------------------------------------------------------------------------
package stwt_pkg;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_STOP   = 3'd1,
        REQ_RESUME = 3'd2,
        REQ_RESET  = 3'd3,
        REQ_LOAD   = 3'd4
    } t_req_type;

    localparam logic [3:0] MAX_TENTH     = 4'd9;
    localparam logic [5:0] MAX_SECOND    = 6'd59;
    localparam logic [3:0] MAX_MINUTE    = 4'd9;
    localparam logic       MODE_COUNT_UP = 1'b0;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] load_minutes;
        logic [5:0] load_seconds;
        logic [3:0] load_tenths;
    } t_req;

    typedef struct packed {
        logic [3:0] minutes;
        logic [5:0] seconds;
        logic [3:0] tenths;
    } t_time;

    typedef struct packed {
        t_time time_val;
        logic  running;
        logic  expired;
        logic  display_changed;
    } t_rsp;

endpackage

// ===== hw/rtl/stwt_ifs.sv =====
// ----------------------------------------------------------------------------
// stwt interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stwt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [3:0] load_minutes;
    logic [5:0] load_seconds;
    logic [3:0] load_tenths;

    modport source (output valid, req_type, load_minutes, load_seconds, load_tenths,
                    input ready);
    modport sink   (input valid, req_type, load_minutes, load_seconds, load_tenths,
                    output ready);
endinterface

interface stwt_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] minutes;
    logic [5:0] seconds;
    logic [3:0] tenths;
    logic       running;
    logic       expired;
    logic       display_changed;

    modport source (output valid, minutes, seconds, tenths, running, expired,
                    display_changed, input ready);
    modport sink   (input valid, minutes, seconds, tenths, running, expired,
                    display_changed, output ready);
endinterface

interface stwt_cfg_if;
    logic valid;
    logic ready;
    logic count_down_mode;

    modport source (output valid, count_down_mode, input ready);
    modport sink   (input valid, count_down_mode, output ready);
endinterface

// ===== hw/rtl/stwt_in_reg.sv =====
// ----------------------------------------------------------------------------
// stwt_in_reg
// Input register stage for request words.
// ----------------------------------------------------------------------------
module stwt_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  stwt_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output stwt_pkg::t_req o_req
);

    logic           r_valid;
    stwt_pkg::t_req r_req;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

// ===== hw/rtl/stwt_core.sv =====
// ----------------------------------------------------------------------------
// stwt_core
// Timer state, next-time logic and result register.
// ----------------------------------------------------------------------------
module stwt_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mode,
    input  logic           i_valid,
    output logic           o_ready,
    input  stwt_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output stwt_pkg::t_rsp o_rsp
);

    stwt_pkg::t_time r_time, n_time;
    logic            r_enabled, n_enabled;
    logic            r_expired, n_expired;
    logic            r_out_valid;
    stwt_pkg::t_rsp  r_rsp;
    logic            w_take;
    logic            w_changed;

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        n_time    = r_time;
        n_enabled = r_enabled;
        n_expired = r_expired;
        w_changed = 1'b0;
        if (w_take) begin
            case (i_req.req_type)
                stwt_pkg::REQ_TICK: begin
                    if (r_enabled) begin
                        w_changed = 1'b1;
                        if (i_mode == stwt_pkg::MODE_COUNT_UP) begin
                            if (r_time.tenths >= stwt_pkg::MAX_TENTH) begin
                                n_time.tenths = '0;
                                if (r_time.seconds >= stwt_pkg::MAX_SECOND) begin
                                    n_time.seconds = '0;
                                    n_time.minutes = (r_time.minutes >= stwt_pkg::MAX_MINUTE)
                                                   ? 4'd0 : r_time.minutes + 4'd1;
                                end else begin
                                    n_time.seconds = r_time.seconds + 6'd1;
                                end
                            end else begin
                                n_time.tenths = r_time.tenths + 4'd1;
                            end
                        end else if (r_time.tenths != 4'd0) begin
                            n_time.tenths = r_time.tenths - 4'd1;
                        end else if (r_time.seconds != 6'd0) begin
                            n_time.tenths  = stwt_pkg::MAX_TENTH;
                            n_time.seconds = r_time.seconds - 6'd1;
                        end else if (r_time.minutes != 4'd0) begin
                            n_time.tenths  = stwt_pkg::MAX_TENTH;
                            n_time.seconds = stwt_pkg::MAX_SECOND;
                            n_time.minutes = r_time.minutes - 4'd1;
                        end else begin
                            n_time    = '0;
                            n_expired = 1'b1;
                            n_enabled = 1'b0;
                        end
                    end
                end
                stwt_pkg::REQ_STOP: begin
                    n_enabled = 1'b0;
                end
                stwt_pkg::REQ_RESUME: begin
                    n_enabled = 1'b1;
                end
                stwt_pkg::REQ_RESET: begin
                    n_enabled = 1'b0;
                    n_time    = '0;
                end
                stwt_pkg::REQ_LOAD: begin
                    n_time.minutes = (i_req.load_minutes > stwt_pkg::MAX_MINUTE)
                                   ? stwt_pkg::MAX_MINUTE : i_req.load_minutes;
                    n_time.seconds = (i_req.load_seconds > stwt_pkg::MAX_SECOND)
                                   ? stwt_pkg::MAX_SECOND : i_req.load_seconds;
                    n_time.tenths  = (i_req.load_tenths > stwt_pkg::MAX_TENTH)
                                   ? stwt_pkg::MAX_TENTH : i_req.load_tenths;
                    n_expired      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_enabled   <= 1'b0;
            r_expired   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_time    <= n_time;
            r_enabled <= n_enabled;
            r_expired <= n_expired;
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp.time_val        <= n_time;
            r_rsp.running         <= n_enabled;
            r_rsp.expired         <= n_expired;
            r_rsp.display_changed <= w_changed;
        end
    end

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.tenths <= stwt_pkg::MAX_TENTH && r_time.seconds <= stwt_pkg::MAX_SECOND
        && r_time.minutes <= stwt_pkg::MAX_MINUTE)
        else $error("timer digit out of range");

    a_expire_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_expired) |-> $past(w_take && i_req.req_type == stwt_pkg::REQ_TICK))
        else $error("expired set by something other than a tick");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_time) && $stable(r_enabled) && $stable(r_expired))
        else $error("timer state moved without a word");

    a_changed_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.display_changed |-> r_rsp.running || r_rsp.expired)
        else $error("display changed while neither running nor expired");

endmodule

// ===== hw/rtl/stopwatch_countdown_timer.sv =====
// ----------------------------------------------------------------------------
// stopwatch_countdown_timer
// Tenths/seconds/minutes stopwatch and countdown timer, one result per word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    req_type, load_minutes, load_seconds, load_tenths
//  o_rsp    out  valid/ready    minutes, seconds, tenths, running, expired,
//                               display_changed
//  i_cfg    in   valid/ready    count_down_mode (ready always high)
//
//  One word per cycle sustained unless o_rsp stalls; the input register feeds
//  the result register. Time update is a single cascaded digit step in the core.
//  Synchronous active-low reset clears time, flags and mode.
//  A stalled result register holds while the input register takes one more word.
// ----------------------------------------------------------------------------
module stopwatch_countdown_timer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stwt_req_if.sink     i_req,
    stwt_rsp_if.source   o_rsp,
    stwt_cfg_if.sink     i_cfg
);

    logic           r_mode;
    stwt_pkg::t_req w_in_req;
    stwt_pkg::t_req w_s1_req;
    stwt_pkg::t_rsp w_rsp;
    logic           w_s1_valid;
    logic           w_s1_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stwt_pkg::MODE_COUNT_UP;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.count_down_mode;
        end
    end

    assign w_in_req.req_type     = i_req.req_type;
    assign w_in_req.load_minutes = i_req.load_minutes;
    assign w_in_req.load_seconds = i_req.load_seconds;
    assign w_in_req.load_tenths  = i_req.load_tenths;

    stwt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_req   (w_in_req),
        .o_valid (w_s1_valid),
        .i_ready (w_s1_ready),
        .o_req   (w_s1_req)
    );

    stwt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_req   (w_s1_req),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_rsp   (w_rsp)
    );

    assign o_rsp.minutes         = w_rsp.time_val.minutes;
    assign o_rsp.seconds         = w_rsp.time_val.seconds;
    assign o_rsp.tenths          = w_rsp.time_val.tenths;
    assign o_rsp.running         = w_rsp.running;
    assign o_rsp.expired         = w_rsp.expired;
    assign o_rsp.display_changed = w_rsp.display_changed;

endmodule
